// File: hdl/modular_power_quotient_macros.svh
// Assertion macros shared by the modular power quotient RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef MODULAR_POWER_QUOTIENT_MACROS_SVH
`define MODULAR_POWER_QUOTIENT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define MPQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is active.
`define MPQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: hdl/mpq_pkg.sv
// Package of the modular power quotient: status codes, sequencer states
// and the status struct of the shared modular multiplier. No dependencies.
package mpq_pkg;

    localparam int unsigned RES_W = 31;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_EXP_ZERO = 2'd1;
    localparam logic [1:0] STATUS_DIV_ZERO = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RED_X,
        ST_RED_Y,
        ST_CHECK,
        ST_INV_SQ,
        ST_INV_MUL,
        ST_FIND,
        ST_SQ,
        ST_SQ_INV,
        ST_MX,
        ST_MX_INV,
        ST_DONE
    } mpq_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mm_stat_t;

endpackage

// File: hdl/mpq_mulmod.sv
// Bit-serial modular multiplier: product = a * b mod p, one bit of b per cycle.
// Depends on mpq_pkg and modular_power_quotient_macros.svh.
`include "modular_power_quotient_macros.svh"

module mpq_mulmod (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [mpq_pkg::RES_W-1:0]  operand_a,
    input  logic [mpq_pkg::RES_W-1:0]  operand_b,
    input  logic [mpq_pkg::RES_W-1:0]  modulus,
    output logic [mpq_pkg::RES_W-1:0]  product,
    output mpq_pkg::mm_stat_t          stat
);
    import mpq_pkg::*;

    logic [RES_W-1:0] a_reg;
    logic [RES_W-1:0] b_reg;
    logic [RES_W-1:0] r_reg;
    logic [RES_W-1:0] r_next;
    logic [4:0]       cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [RES_W:0] pm;
    logic [RES_W:0] dbl;
    logic [RES_W:0] dbl_red;
    logic [RES_W:0] sum;
    logic [RES_W:0] sum_red;

    // Operand a is below p, so r stays below p after each doubling and add.
    always_comb
    begin
        pm      = {1'b0, modulus};
        dbl     = {r_reg, 1'b0};
        dbl_red = (dbl >= pm) ? (dbl - pm) : dbl;
        sum     = dbl_red + (b_reg[cnt_reg] ? {1'b0, a_reg} : '0);
        sum_red = (sum >= pm) ? (sum - pm) : sum;
        r_next  = sum_red[RES_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !busy_reg && !done_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'(RES_W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 5'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy_reg && !done_reg)
        begin
            a_reg <= operand_a;
            b_reg <= operand_b;
            r_reg <= '0;
        end
        else if (busy_reg)
        begin
            r_reg <= r_next;
        end
    end

    assign product   = r_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

    `MPQ_ASSERT_NXT(a_done_pulse, clk, rst_n, done_reg, !done_reg)
    `MPQ_ASSERT_NXT(a_start_busy, clk, rst_n, start && !busy_reg && !done_reg, busy_reg)
    `MPQ_ASSERT_IMP(a_busy_excl, clk, rst_n, busy_reg, !done_reg)

endmodule

// File: hdl/modular_power_quotient.sv
// Top level of the modular power quotient: x^n / y^(n-1) mod p.
// Depends on mpq_pkg, mpq_mulmod and modular_power_quotient_macros.svh.
//
//  Channel     Ports                                      Handshake
//  ---------   ----------------------------------------   -------------------------
//  command     base_value, divisor_value, exponent        start while busy is low
//  result      result_value, status                       done, one-cycle strobe
//  config      prime_modulus                              prime_modulus_we
//
// Every modular product goes through one bit-serial multiplier, which is
// started, steps through the 31 bits of b and then reports done. An item
// with n above one costs two reductions, up to 62 products for the Fermat
// inverse y^(p-2), a scan in ST_FIND for the leading exponent bit, and up
// to four products per remaining exponent bit. A zero exponent or a modulus
// below two goes from ST_IDLE straight to ST_DONE; n one and a zero divisor
// finish after the two reductions and ST_CHECK. Reset returns the sequencer
// to idle and the modulus to 2^31-1. The result receiver cannot stall: done
// is high for one cycle.
`include "modular_power_quotient_macros.svh"

module modular_power_quotient #(
    parameter int EXP_BITS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [mpq_pkg::RES_W-1:0]  base_value,
    input  logic [mpq_pkg::RES_W-1:0]  divisor_value,
    input  logic [EXP_BITS-1:0]        exponent,
    output logic                       done,
    output logic [mpq_pkg::RES_W-1:0]  result_value,
    output logic [1:0]                 status,
    input  logic                       prime_modulus_we,
    input  logic [mpq_pkg::RES_W-1:0]  prime_modulus
);
    import mpq_pkg::*;

    localparam int IDX_W = $clog2(EXP_BITS);

    mpq_state_t state_reg, state_next;

    // Modulus; written by the user only while the block is idle, not enforced.
    logic [RES_W-1:0] p_reg;

    logic [RES_W-1:0]    base_reg,   base_next;
    logic [RES_W-1:0]    div_reg,    div_next;
    logic [EXP_BITS-1:0] exp_reg,    exp_next;
    logic [RES_W-1:0]    x_reg,      x_next;
    logic [RES_W-1:0]    y_reg,      y_next;
    logic [RES_W-1:0]    inv_reg,    inv_next;
    logic [RES_W-1:0]    c_reg,      c_next;
    logic [1:0]          status_reg, status_next;
    logic [4:0]          k_reg,      k_next;
    logic [IDX_W-1:0]    idx_reg,    idx_next;

    logic             accept;
    logic             mul_state;
    logic             mul_start;
    logic [RES_W-1:0] mul_a;
    logic [RES_W-1:0] mul_b;
    logic [RES_W-1:0] mul_p;
    logic [RES_W-1:0] mul_q;
    mm_stat_t         mul_stat;
    logic [RES_W-1:0] inv_exp;

    assign accept  = start && (state_reg == ST_IDLE);
    // Fermat exponent p-2; only used once p is known to be at least two.
    assign inv_exp = p_reg - RES_W'(2);

    mpq_mulmod u_mulmod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mul_start),
        .operand_a (mul_a),
        .operand_b (mul_b),
        .modulus   (mul_p),
        .product   (mul_q),
        .stat      (mul_stat)
    );

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    // Zero exponent and a modulus below two are settled at once.
                    if (exponent == '0 || p_reg < RES_W'(2))
                        state_next = ST_DONE;
                    else
                        state_next = ST_RED_X;
                end
            end
            ST_RED_X:   if (mul_stat.done) state_next = ST_RED_Y;
            ST_RED_Y:   if (mul_stat.done) state_next = ST_CHECK;
            ST_CHECK:
            begin
                if (exp_reg == EXP_BITS'(1) || y_reg == '0)
                    state_next = ST_DONE;
                else
                    state_next = ST_INV_SQ;
            end
            ST_INV_SQ:
            begin
                if (mul_stat.done)
                begin
                    if (inv_exp[k_reg])
                        state_next = ST_INV_MUL;
                    else if (k_reg == '0)
                        state_next = ST_FIND;
                end
            end
            ST_INV_MUL:
            begin
                if (mul_stat.done)
                    state_next = (k_reg == '0) ? ST_FIND : ST_INV_SQ;
            end
            ST_FIND:    if (exp_reg[idx_reg]) state_next = ST_SQ;
            ST_SQ:      if (mul_stat.done) state_next = ST_SQ_INV;
            ST_SQ_INV:
            begin
                if (mul_stat.done)
                begin
                    if (exp_reg[idx_reg])
                        state_next = ST_MX;
                    else if (idx_reg == '0)
                        state_next = ST_DONE;
                    else
                        state_next = ST_SQ;
                end
            end
            ST_MX:      if (mul_stat.done) state_next = ST_MX_INV;
            ST_MX_INV:
            begin
                if (mul_stat.done)
                    state_next = (idx_reg == '0) ? ST_DONE : ST_SQ;
            end
            ST_DONE:    state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // Datapath register updates; each product lands in its target when the
    // multiplier reports done.
    always_comb
    begin
        base_next   = base_reg;
        div_next    = div_reg;
        exp_next    = exp_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        inv_next    = inv_reg;
        c_next      = c_reg;
        status_next = status_reg;
        k_next      = k_reg;
        idx_next    = idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    base_next   = base_value;
                    div_next    = divisor_value;
                    exp_next    = exponent;
                    c_next      = '0;
                    status_next = STATUS_OK;
                    if (exponent == '0)
                        status_next = STATUS_EXP_ZERO;
                    else if (p_reg < RES_W'(2) && exponent != EXP_BITS'(1))
                        status_next = STATUS_DIV_ZERO;
                end
            end
            ST_RED_X:   if (mul_stat.done) x_next = mul_q;
            ST_RED_Y:   if (mul_stat.done) y_next = mul_q;
            ST_CHECK:
            begin
                inv_next = RES_W'(1);
                k_next   = 5'(RES_W - 1);
                idx_next = IDX_W'(EXP_BITS - 1);
                if (exp_reg == EXP_BITS'(1))
                    c_next = x_reg;
                else if (y_reg == '0)
                    status_next = STATUS_DIV_ZERO;
            end
            ST_INV_SQ:
            begin
                if (mul_stat.done)
                begin
                    inv_next = mul_q;
                    if (!inv_exp[k_reg] && k_reg != '0)
                        k_next = k_reg - 5'd1;
                end
            end
            ST_INV_MUL:
            begin
                if (mul_stat.done)
                begin
                    inv_next = mul_q;
                    if (k_reg != '0)
                        k_next = k_reg - 5'd1;
                end
            end
            ST_FIND:
            begin
                // The leading bit is at one or above, since n is at least two.
                if (exp_reg[idx_reg])
                    c_next = x_reg;
                if (idx_reg != '0)
                    idx_next = idx_reg - IDX_W'(1);
            end
            ST_SQ:      if (mul_stat.done) c_next = mul_q;
            ST_SQ_INV:
            begin
                if (mul_stat.done)
                begin
                    c_next = mul_q;
                    if (!exp_reg[idx_reg] && idx_reg != '0)
                        idx_next = idx_reg - IDX_W'(1);
                end
            end
            ST_MX:      if (mul_stat.done) c_next = mul_q;
            ST_MX_INV:
            begin
                if (mul_stat.done)
                begin
                    c_next = mul_q;
                    if (idx_reg != '0)
                        idx_next = idx_reg - IDX_W'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    // Multiplier operands and the handshake outputs.
    always_comb
    begin
        mul_state = 1'b1;
        mul_a     = c_reg;
        mul_b     = c_reg;
        case (state_reg)
            ST_RED_X:
            begin
                mul_a = RES_W'(1);
                mul_b = base_reg;
            end
            ST_RED_Y:
            begin
                mul_a = RES_W'(1);
                mul_b = div_reg;
            end
            ST_INV_SQ:
            begin
                mul_a = inv_reg;
                mul_b = inv_reg;
            end
            ST_INV_MUL:
            begin
                mul_a = inv_reg;
                mul_b = y_reg;
            end
            ST_SQ:
            begin
                mul_a = c_reg;
                mul_b = c_reg;
            end
            ST_SQ_INV, ST_MX_INV:
            begin
                mul_a = c_reg;
                mul_b = inv_reg;
            end
            ST_MX:
            begin
                mul_a = c_reg;
                mul_b = x_reg;
            end
            default:
            begin
                mul_state = 1'b0;
            end
        endcase
        mul_p        = p_reg;
        mul_start    = mul_state && !mul_stat.busy && !mul_stat.done;
        busy         = (state_reg != ST_IDLE);
        done         = (state_reg == ST_DONE);
        result_value = c_reg;
        status       = status_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            p_reg     <= {RES_W{1'b1}};
        end
        else
        begin
            state_reg <= state_next;
            if (prime_modulus_we)
                p_reg <= prime_modulus;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg   <= base_next;
        div_reg    <= div_next;
        exp_reg    <= exp_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        inv_reg    <= inv_next;
        c_reg      <= c_next;
        status_reg <= status_next;
        k_reg      <= k_next;
        idx_reg    <= idx_next;
    end

    `MPQ_ASSERT_NXT(a_done_to_idle, clk, rst_n, state_reg == ST_DONE, !busy)
    `MPQ_ASSERT_NXT(a_exp_zero_fast, clk, rst_n, accept && exponent == '0, done)
    `MPQ_ASSERT_IMP(a_mul_owned, clk, rst_n, mul_stat.done, mul_state)

endmodule

// File: tb/tb.sv
// Testbench for modular_power_quotient: x^n / y^(n-1) mod p.
// Depends on mpq_pkg and the RTL; a built-in predictor checks every result transfer.
`timescale 1ns / 100ps

module tb;
    import mpq_pkg::*;

    localparam int EXP_BITS = 16;
    localparam int IDLE_LIMIT = 20000;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [RES_W-1:0]    base_value;
    logic [RES_W-1:0]    divisor_value;
    logic [EXP_BITS-1:0] exponent;
    logic                done;
    logic [RES_W-1:0]    result_value;
    logic [1:0]          status;
    logic                prime_modulus_we;
    logic [RES_W-1:0]    prime_modulus;

    typedef struct packed {
        logic [RES_W-1:0] value;
        logic [1:0]       code;
    } quotient_t;

    // Predictor copy of the modulus register.
    logic [RES_W-1:0] modulus_copy;
    quotient_t        pending_quotients[$];
    int               mismatch_count;
    int               item_count;
    int               result_count;
    int               idle_cycles;

    modular_power_quotient #(.EXP_BITS(EXP_BITS)) u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .base_value(base_value), .divisor_value(divisor_value), .exponent(exponent),
        .done(done), .result_value(result_value), .status(status),
        .prime_modulus_we(prime_modulus_we), .prime_modulus(prime_modulus)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [63:0] mul_reduce(logic [63:0] a, logic [63:0] b,
                                               logic [63:0] p);
        return (a * b) % p;
    endfunction

    function automatic logic [63:0] raise_mod(logic [63:0] b, logic [63:0] e,
                                              logic [63:0] p);
        logic [63:0] r;
        r = 1 % p;
        while (e != 0)
        begin
            if (e[0]) r = mul_reduce(r, b, p);
            b = mul_reduce(b, b, p);
            e = e >> 1;
        end
        return r;
    endfunction

    // Works out the expected result of one command from the current modulus.
    function automatic quotient_t predict_quotient(logic [RES_W-1:0] xin,
                                                   logic [RES_W-1:0] yin,
                                                   logic [EXP_BITS-1:0] n);
        quotient_t   q;
        logic [63:0] p;
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] inv;
        logic [63:0] c;
        int          top;
        p = modulus_copy;
        x = (p < 2) ? 0 : xin % p;
        y = (p < 2) ? 0 : yin % p;
        q.value = '0;
        q.code = STATUS_OK;
        if (n == 0)
        begin
            q.code = STATUS_EXP_ZERO;
            return q;
        end
        if (n == 1)
        begin
            q.value = x[RES_W-1:0];
            return q;
        end
        if (y == 0)
        begin
            q.code = STATUS_DIV_ZERO;
            return q;
        end
        inv = raise_mod(y, p - 2, p);
        top = 0;
        for (int i = EXP_BITS - 1; i >= 0; i--)
        begin
            if (n[i])
            begin
                top = i;
                break;
            end
        end
        c = x;
        for (int i = top - 1; i >= 0; i--)
        begin
            c = mul_reduce(mul_reduce(c, c, p), inv, p);
            if (n[i]) c = mul_reduce(mul_reduce(c, x, p), inv, p);
        end
        q.value = c[RES_W-1:0];
        return q;
    endfunction

    // Result checker: every strobe is a transfer that must match the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            quotient_t want;
            result_count++;
            if (pending_quotients.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result value=%0d status=%0d",
                             result_value, status);
            end
            else
            begin
                want = pending_quotients.pop_front();
                if (want.value !== result_value || want.code !== status)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected value=%0d status=%0d, got value=%0d status=%0d",
                                 want.value, want.code, result_value, status);
                end
            end
        end
    end

    // Watchdog: counts cycles with no transfer on either channel.
    always @(posedge clk)
    begin
        if (!rst_n || done || (start && !busy))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Sends one command after a random gap and waits for its transfer.
    task automatic send_command(logic [RES_W-1:0] x, logic [RES_W-1:0] y,
                                logic [EXP_BITS-1:0] n);
        int gap;
        gap = $urandom_range(0, 14);
        repeat (gap) @(posedge clk);
        start <= 1'b1;
        base_value <= x;
        divisor_value <= y;
        exponent <= n;
        do @(posedge clk); while (busy);
        pending_quotients.push_back(predict_quotient(x, y, n));
        item_count++;
        start <= 1'b0;
        @(posedge clk);
    endtask

    // Waits until every result has arrived, then lets the block settle.
    task automatic drain_results();
        while (pending_quotients.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_modulus(logic [RES_W-1:0] p);
        drain_results();
        prime_modulus_we <= 1'b1;
        prime_modulus <= p;
        @(posedge clk);
        prime_modulus_we <= 1'b0;
        modulus_copy = p;
    endtask

    // Extremes of every field and each named special case, at reset modulus.
    task automatic test_directed();
        send_command('0, '0, '0);
        send_command('1, '1, '0);
        send_command(31'd12345, 31'd0, 16'd1);
        send_command(31'h7FFF_FFFF, 31'd5, 16'd1);
        send_command(31'd7, 31'd0, 16'd2);
        send_command(31'd7, 31'h7FFF_FFFF, 16'd5);
        send_command(31'd3, 31'd2, 16'd2);
        send_command(31'h7FFF_FFFE, 31'h7FFF_FFFE, 16'hFFFF);
        send_command(31'h5555_5555, 31'h2AAA_AAAA, 16'h8000);
        send_command(31'h2AAA_AAAA, 31'h5555_5555, 16'h7FFF);
        send_command(31'd1, 31'd1, 16'd3);
        send_command(31'd0, 31'd9, 16'd4);
    endtask

    task automatic test_small_moduli();
        write_modulus(31'd0);
        send_command(31'd5, 31'd3, 16'd1);
        send_command(31'd5, 31'd3, 16'd7);
        write_modulus(31'd1);
        send_command(31'd5, 31'd3, 16'd0);
        send_command(31'd5, 31'd3, 16'd9);
        write_modulus(31'd2);
        send_command(31'd5, 31'd3, 16'd6);
        send_command(31'd4, 31'd3, 16'd2);
        write_modulus(31'd15);
        send_command(31'd7, 31'd4, 16'd11);
        send_command(31'd7, 31'd30, 16'd3);
    endtask

    // Random commands at one given modulus, mostly exponents above one.
    task automatic test_random(int count, logic [RES_W-1:0] p);
        logic [RES_W-1:0]    x;
        logic [RES_W-1:0]    y;
        logic [EXP_BITS-1:0] n;
        write_modulus(p);
        for (int k = 0; k < count; k++)
        begin
            x = $urandom();
            y = $urandom();
            case ($urandom_range(0, 9))
                0: n = $urandom_range(0, 1);
                1: n = $urandom_range(2, 15);
                default: n = $urandom();
            endcase
            if ($urandom_range(0, 15) == 0) y = '0;
            if ($urandom_range(0, 15) == 0) y = p;
            if ($urandom_range(0, 7) == 0) x = $urandom_range(0, 3);
            send_command(x, y, n);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        base_value = '0;
        divisor_value = '0;
        exponent = '0;
        prime_modulus_we = 1'b0;
        prime_modulus = '0;
        modulus_copy = 31'h7FFF_FFFF;
        mismatch_count = 0;
        item_count = 0;
        result_count = 0;
        idle_cycles = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_small_moduli();
        test_random(150, 31'h7FFF_FFFF);
        test_random(100, 31'd65521);
        test_random(100, 31'd1000003);
        test_random(60, 31'd3);
        test_random(40, 31'd91);
        test_random(50, 31'h7FFF_FFFF);
        drain_results();

        $display("covered %0d commands and %0d results over eleven modulus settings",
                 item_count, result_count);
        if (mismatch_count == 0 && pending_quotients.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
